### hdl/lcsm_pkg.sv
// lcsm_pkg: shared constants, codes and helpers of the load cell stability monitor
// no dependencies
`default_nettype none
package lcsm_pkg;

	localparam int HISTORY_DEPTH = 32;
	localparam int SAMPLE_BITS   = 24;
	localparam int SPREAD_W      = 56;
	localparam int GAIN_FRAC     = 24;
	localparam int REF_W         = 32;
	localparam int SAT_W         = 128;

	localparam logic [SPREAD_W-1:0] SPREAD_MAX = '1;

	localparam logic [30:0] CAPACITY_RST  = 31'h7FFF_FFFF;
	localparam logic [15:0] LIMIT_RST     = 16'd100;
	localparam logic [23:0] ZERO_BAND_RST = 24'd100;

	localparam logic [5:0] FLAG_KEEP_ZERO     = 6'h0B;
	localparam logic [5:0] FLAG_KEEP_STABLE   = 6'h07;
	localparam logic [5:0] FLAG_KEEP_UNSTABLE = 6'h13;
	localparam logic [5:0] FLAG_KEEP_OVERLOAD = 6'h23;
	localparam logic [5:0] FLAG_SET_ZERO      = 6'h0A;
	localparam logic [5:0] FLAG_SET_STABLE    = 6'h04;
	localparam logic [5:0] FLAG_SET_UNSTABLE  = 6'h10;
	localparam logic [5:0] FLAG_SET_OVERLOAD  = 6'h20;

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_ZERO   = 2'd1,
		FUNC_REF    = 2'd2,
		FUNC_POLL   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_OFFSET    = 2'd0,
		REG_CAPACITY  = 2'd1,
		REG_LIMIT     = 2'd2,
		REG_ZERO_BAND = 2'd3
	} reg_idx_t;

	function automatic logic [31:0] sat32(input logic neg, input logic [SAT_W-1:0] mag);
		logic [31:0] r;
		if (neg) begin
			if (mag > SAT_W'(32'h8000_0000))
				r = 32'h8000_0000;
			else
				r = 32'(~mag[31:0] + 32'd1);
		end else begin
			if (mag > SAT_W'(32'h7FFF_FFFF))
				r = 32'h7FFF_FFFF;
			else
				r = mag[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/lcsm_ram.sv
// lcsm_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module lcsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hdl/lcsm_div.sv
// lcsm_div: restoring unsigned divider, one quotient bit per cycle
// no dependencies
`default_nettype none
module lcsm_div #(
	parameter int NW = 56,
	parameter int VW = 26
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic      [NW-1:0] quotient
);
	localparam int CW = $clog2(NW + 1);

	logic [VW:0]   rem_q;
	logic [VW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [VW:0]   rem_sh;
	logic          ge;

	assign rem_sh = {rem_q[VW-1:0], quotient[NW-1]};
	assign ge     = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= '0;
			div_q    <= divisor;
			quotient <= dividend;
		end else if (busy_q) begin
			rem_q    <= ge ? rem_sh - {1'b0, div_q} : rem_sh;
			quotient <= {quotient[NW-2:0], ge};
		end
	end

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");
endmodule
`default_nettype wire

### hdl/lcsm_mul.sv
// lcsm_mul: unsigned multiplier with registered product
// no dependencies
`default_nettype none
module lcsm_mul #(
	parameter int MW = 32
) (
	input  wire logic            clk,
	input  wire logic [MW-1:0]   a,
	input  wire logic [MW-1:0]   b,
	output logic      [2*MW-1:0] p
);
	always_ff @(posedge clk) begin
		p <= (2*MW)'(a) * (2*MW)'(b);
	end
endmodule
`default_nettype wire

### hdl/load_cell_stability_monitor.sv
// load_cell_stability_monitor: top level, sequencer around shared divider and multiplier
// depends on lcsm_pkg, lcsm_ram, lcsm_div, lcsm_mul
//
// channel | dir | handshake        | payload
// s_      | in  | s_tvalid/tready  | tuser func, tdata sample + reference_weight
// m_      | out | m_tvalid/tready  | tdata average, weight, status, events, spread
// apb     | in  | psel/penable     | four registers at 4*i
//
// sample: accept, update (sum, weight mul, saturate), spread walk, compare, result
// a depth that is not a power of two adds a divider pass for the mean
// set reference: uses the shared divider if flag bit 0 is set and dz is nonzero
// the spread walk reads one history entry a cycle through the shared multiplier
// reset clears history through per-entry valid bits, no clearing pass
// s_tready is low from acceptance until the result is taken, a stalled m_tready extends it
`default_nettype none
module load_cell_stability_monitor #(
	parameter int HISTORY_DEPTH = lcsm_pkg::HISTORY_DEPTH,
	parameter int SAMPLE_BITS   = lcsm_pkg::SAMPLE_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// sample, reference_weight
	input  wire logic [((SAMPLE_BITS+32+7)/8)*8-1:0] s_tdata,
	// func
	input  wire logic [1:0] s_tuser,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// average, weight, status_flags, events, spread_sum
	output logic [((SAMPLE_BITS+1+32+6+4+56+7)/8)*8-1:0] m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	localparam int S    = SAMPLE_BITS;
	localparam int D    = HISTORY_DEPTH;
	localparam int AW   = $clog2(D);
	localparam int HW   = S + 1;
	localparam int DW   = S + 2;
	localparam int RW   = S + 2 + AW;
	localparam int MW   = (DW > 32) ? DW : 32;
	localparam int PW   = 2 * MW;
	localparam int NW   = (RW > 56) ? RW : 56;
	localparam int VW   = DW;
	localparam int CW   = $clog2(D + 1);
	localparam int SPW  = lcsm_pkg::SPREAD_W;
	localparam int ACW  = ((PW + 1) > (SPW + 1)) ? (PW + 1) : (SPW + 1);
	localparam int LW   = 16 + AW;
	localparam int ZW   = (S > 24) ? S + 1 : 25;
	localparam int ODW  = ((S + 1 + 32 + 6 + 4 + 56 + 7) / 8) * 8;
	localparam int OPAD = ODW - (S + 1 + 32 + 6 + 4 + 56);
	localparam bit D_POW2 = ((D & (D - 1)) == 0);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SUM, ST_MDIV, ST_WMUL, ST_WSAT, ST_SPR, ST_CMP, ST_CDIV, ST_OUT
	} state_t;

	state_t state_q;

	logic signed [S-1:0] offset_q;
	logic [30:0]         capacity_q;
	logic [15:0]         limit_q;
	logic [23:0]         zero_band_q;

	logic signed [HW-1:0] v_q, mean_q, zero_q;
	logic signed [RW-1:0] sum_q;
	logic signed [31:0]   gain_q, weight_q;
	logic [5:0]           flags_q;
	logic [3:0]           events_q;
	logic [SPW-1:0]       spread_q;
	logic [SPW-1:0]       acc_q;
	logic [AW-1:0]        wi_q;
	logic [D-1:0]         hval_q;
	logic                 hval_s1;
	logic                 neg_q;
	logic [CW-1:0]        rd_cnt_q;
	logic                 v_s1, v_s2, v_s3;
	logic [DW-1:0]        mag_s2;

	logic                 accept;
	lcsm_pkg::func_t      func;
	logic signed [S-1:0]  sample;
	logic signed [31:0]   ref_w;
	logic signed [HW-1:0] old_h;
	logic signed [RW-1:0] sum_nxt;
	logic [RW-1:0]        sum_mag;
	logic [RW-1:0]        mean_mag;
	logic signed [DW-1:0] dz;
	logic [DW-1:0]        dz_mag;
	logic [31:0]          gain_mag;
	logic signed [DW-1:0] hdiff;
	logic [DW-1:0]        hdiff_mag;
	logic [ACW-1:0]       acc_sum;
	logic [LW-1:0]        lim_scaled;

	logic                 ram_we;
	logic [AW-1:0]        ram_raddr;
	logic [HW-1:0]        ram_rdata;

	logic                 div_start, div_done;
	logic [NW-1:0]        div_n, div_q;
	logic [VW-1:0]        div_v;

	logic [MW-1:0]        mul_a;
	logic [PW-1:0]        mul_p;

	logic [5:0]           pf;
	logic [3:0]           pev;
	logic signed [31:0]   pw;
	logic [ZW-1:0]        zdist;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign func     = lcsm_pkg::func_t'(s_tuser);
	assign sample   = s_tdata[S-1:0];
	assign ref_w    = s_tdata[S+31:S];
	assign pready   = 1'b1;

	assign m_tdata = {{OPAD{1'b0}}, spread_q, events_q, flags_q, weight_q, mean_q};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			capacity_q  <= lcsm_pkg::CAPACITY_RST;
			limit_q     <= lcsm_pkg::LIMIT_RST;
			zero_band_q <= lcsm_pkg::ZERO_BAND_RST;
		end else if (psel && penable && pwrite) begin
			unique case (lcsm_pkg::reg_idx_t'(paddr[3:2]))
				lcsm_pkg::REG_OFFSET:    offset_q    <= pwdata[S-1:0];
				lcsm_pkg::REG_CAPACITY:  capacity_q  <= pwdata[30:0];
				lcsm_pkg::REG_LIMIT:     limit_q     <= pwdata[15:0];
				lcsm_pkg::REG_ZERO_BAND: zero_band_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (lcsm_pkg::reg_idx_t'(paddr[3:2]))
			lcsm_pkg::REG_OFFSET:    prdata = 32'(offset_q);
			lcsm_pkg::REG_CAPACITY:  prdata = {1'b0, capacity_q};
			lcsm_pkg::REG_LIMIT:     prdata = {16'd0, limit_q};
			lcsm_pkg::REG_ZERO_BAND: prdata = {8'd0, zero_band_q};
			default:                 prdata = '0;
		endcase
	end

	// datapath helpers
	assign old_h     = hval_s1 ? ram_rdata : '0;
	assign sum_nxt   = sum_q + RW'(v_q) - RW'(old_h);
	assign sum_mag   = sum_nxt[RW-1] ? RW'(-sum_nxt) : RW'(sum_nxt);
	assign mean_mag  = sum_mag >> AW;
	assign dz        = DW'(mean_q) - DW'(zero_q);
	assign dz_mag    = dz[DW-1] ? DW'(-dz) : DW'(dz);
	assign gain_mag  = gain_q[31] ? 32'(-gain_q) : 32'(gain_q);
	assign hdiff     = DW'(old_h) - DW'(mean_q);
	assign hdiff_mag = hdiff[DW-1] ? DW'(-hdiff) : DW'(hdiff);
	assign acc_sum   = ACW'(acc_q) + ACW'(mul_p);
	assign lim_scaled = LW'(limit_q) * LW'(D - 1);

	assign ram_we    = (state_q == ST_SUM);
	assign ram_raddr = (state_q == ST_SPR) ? rd_cnt_q[AW-1:0] : wi_q;
	assign mul_a     = (state_q == ST_WMUL) ? MW'(dz_mag) : MW'(mag_s2);

	always_comb begin
		div_start = 1'b0;
		div_n     = NW'(sum_mag);
		div_v     = VW'(D);
		if (state_q == ST_SUM && !D_POW2) begin
			div_start = 1'b1;
		end else if (accept && func == lcsm_pkg::FUNC_REF && flags_q[0] && dz != '0) begin
			div_start = 1'b1;
			div_n     = NW'({(ref_w[31] ? 32'(-ref_w) : 32'(ref_w)),
				{lcsm_pkg::GAIN_FRAC{1'b0}}});
			div_v     = dz_mag;
		end
	end

	// poll event logic
	always_comb begin
		pf    = flags_q;
		pev   = '0;
		pw    = weight_q;
		zdist = ZW'(dz[S-1:0]);
		if (pf[0]) begin
			if (zdist <= ZW'(zero_band_q) && !pf[3]) begin
				pw     = '0;
				pf     = (pf | lcsm_pkg::FLAG_SET_ZERO) & lcsm_pkg::FLAG_KEEP_ZERO;
				pev[0] = 1'b1;
			end else if (!pf[2]) begin
				pf     = (pf | lcsm_pkg::FLAG_SET_STABLE) & lcsm_pkg::FLAG_KEEP_STABLE;
				pev[1] = 1'b1;
			end
		end else if (!pf[4]) begin
			pf     = (pf | lcsm_pkg::FLAG_SET_UNSTABLE) & lcsm_pkg::FLAG_KEEP_UNSTABLE;
			pev[2] = 1'b1;
		end
		if (pw >= $signed({1'b0, capacity_q}) && !pf[5]) begin
			pf     = (pf | lcsm_pkg::FLAG_SET_OVERLOAD) & lcsm_pkg::FLAG_KEEP_OVERLOAD;
			pev[3] = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wi_q     <= '0;
			hval_q   <= '0;
			hval_s1  <= 1'b0;
			sum_q    <= '0;
			mean_q   <= '0;
			zero_q   <= '0;
			gain_q   <= '0;
			weight_q <= '0;
			flags_q  <= '0;
			events_q <= '0;
			spread_q <= '0;
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			hval_s1 <= hval_q[ram_raddr];
			v_s1    <= (state_q == ST_SPR) && (rd_cnt_q < CW'(D));
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						events_q <= '0;
						unique case (func)
							lcsm_pkg::FUNC_SAMPLE: state_q <= ST_SUM;
							lcsm_pkg::FUNC_ZERO: begin
								if (flags_q[0])
									zero_q <= mean_q;
								state_q <= ST_OUT;
							end
							lcsm_pkg::FUNC_REF: begin
								state_q <= div_start ? ST_CDIV : ST_OUT;
								neg_q   <= ref_w[31] ^ dz[DW-1];
							end
							lcsm_pkg::FUNC_POLL: begin
								flags_q  <= pf;
								events_q <= pev;
								weight_q <= pw;
								state_q  <= ST_OUT;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_SUM: begin
					sum_q        <= sum_nxt;
					neg_q        <= sum_nxt[RW-1];
					hval_q[wi_q] <= 1'b1;
					wi_q         <= (wi_q == AW'(D - 1)) ? '0 : wi_q + AW'(1);
					if (D_POW2) begin
						mean_q  <= sum_nxt[RW-1] ? HW'(-mean_mag) : HW'(mean_mag);
						state_q <= ST_WMUL;
					end else begin
						state_q <= ST_MDIV;
					end
				end
				ST_MDIV: begin
					if (div_done) begin
						mean_q  <= neg_q ? HW'(-div_q) : HW'(div_q);
						state_q <= ST_WMUL;
					end
				end
				ST_WMUL: begin
					neg_q   <= dz[DW-1] ^ gain_q[31];
					state_q <= ST_WSAT;
				end
				ST_WSAT: begin
					weight_q <= lcsm_pkg::sat32(neg_q,
						lcsm_pkg::SAT_W'(mul_p[PW-1:lcsm_pkg::GAIN_FRAC]));
					acc_q    <= '0;
					rd_cnt_q <= '0;
					state_q  <= ST_SPR;
				end
				ST_SPR: begin
					if (rd_cnt_q < CW'(D))
						rd_cnt_q <= rd_cnt_q + CW'(1);
					if (v_s3)
						acc_q <= (acc_sum > ACW'(lcsm_pkg::SPREAD_MAX)) ?
							lcsm_pkg::SPREAD_MAX : acc_sum[SPW-1:0];
					if (rd_cnt_q == CW'(D) && !v_s1 && !v_s2 && !v_s3)
						state_q <= ST_CMP;
				end
				ST_CMP: begin
					spread_q   <= acc_q;
					flags_q[0] <= !(acc_q >= SPW'(lim_scaled));
					state_q    <= ST_OUT;
				end
				ST_CDIV: begin
					if (div_done) begin
						gain_q  <= lcsm_pkg::sat32(neg_q, lcsm_pkg::SAT_W'(div_q));
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= hdiff_mag;
	end

	lcsm_ram #(.WIDTH(HW), .DEPTH(D)) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wi_q),
		.wdata (v_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lcsm_div #(.NW(NW), .VW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_v),
		.done     (div_done),
		.quotient (div_q)
	);

	lcsm_mul #(.MW(MW)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   ((state_q == ST_WMUL) ? MW'(gain_mag) : MW'(mag_s2)),
		.p   (mul_p)
	);

	// offset-corrected sample captured at acceptance
	always_ff @(posedge clk) begin
		if (accept)
			v_q <= HW'(sample) - HW'(offset_q);
	end

	property p_excl;
		@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid);
	endproperty
	a_excl: assert property (p_excl) else $error("ready while result pending");

	property p_zero_sticky;
		@(posedge clk) disable iff (!arst_n) flags_q[1] |=> flags_q[1];
	endproperty
	a_zero_sticky: assert property (p_zero_sticky) else $error("zero flag cleared");

	property p_wi_range;
		@(posedge clk) disable iff (!arst_n) wi_q <= AW'(D - 1);
	endproperty
	a_wi_range: assert property (p_wi_range) else $error("write index out of range");

	property p_div_state;
		@(posedge clk) disable iff (!arst_n)
			div_done |-> (state_q == ST_MDIV || state_q == ST_CDIV);
	endproperty
	a_div_state: assert property (p_div_state) else $error("divider done outside wait");
endmodule
`default_nettype wire
